FILE: rtl/cbc_pkg.sv
// shared widths, stage indexes, config codes and the pipeline record
// for the circle versus box contact pipeline; no dependencies
package cbc_pkg;

    localparam int CW = 32;
    localparam int FB = 16;

    localparam int NSQ  = CW - 1;
    localparam int NDIV = FB;

    localparam int ST_CLAMP  = 1;
    localparam int ST_DIFF   = 2;
    localparam int ST_SQR    = 3;
    localparam int ST_HIT    = 4;
    localparam int ST_SQ0    = 5;
    localparam int ST_DINIT  = ST_SQ0 + NSQ;
    localparam int ST_DSTEP0 = ST_DINIT + 1;
    localparam int ST_OUT    = ST_DSTEP0 + NDIV;
    localparam int NSTAGE    = ST_OUT + 1;

    localparam int EPS_LIMIT = (2 ** FB + 999999) / 1000000;

    localparam int IN_BITS  = 4 * CW + 128;
    localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS = 128 + 2 * (FB + 2) + 2 * (CW - 1) + 2 * CW + FB + 1;
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

    localparam logic [7:0] CFG_CENTER_X = 8'd0;
    localparam logic [7:0] CFG_CENTER_Y = 8'd1;
    localparam logic [7:0] CFG_RADIUS   = 8'd2;
    localparam logic [7:0] CFG_MASK     = 8'd3;

    typedef struct packed {
        logic                   valid;
        logic [31:0]            id;
        logic [31:0]            layer;
        logic [63:0]            user;
        logic signed [CW-1:0]   cx;
        logic signed [CW-1:0]   cy;
        logic [CW-2:0]          rad;
        logic signed [CW-1:0]   bx0;
        logic signed [CW-1:0]   by0;
        logic signed [CW-1:0]   bx1;
        logic signed [CW-1:0]   by1;
        logic signed [CW-1:0]   px;
        logic signed [CW-1:0]   py;
        logic                   sx;
        logic                   sy;
        logic [CW-1:0]          ax;
        logic [CW-1:0]          ay;
        logic [2*CW-1:0]        sqx;
        logic [2*CW-1:0]        sqy;
        logic [2*CW-3:0]        rsq;
        logic [2*CW-2:0]        rem;
        logic [CW-2:0]          root;
        logic                   ctr_in;
        logic [2:0][CW-1:0]     dr;
        logic [2:0][FB+1:0]     dq;
        logic [FB+1:0]          nx;
        logic [FB+1:0]          ny;
        logic [CW-2:0]          pen;
        logic [CW-1:0]          ox;
        logic [CW-1:0]          oy;
        logic [CW-2:0]          dlen;
        logic [FB:0]            frac;
    } t_pipe;

endpackage

FILE: rtl/circle_box_contact.sv
// throughput: one box per cycle unless a result stall holds the pipeline; sqrt
// takes one root bit per stage, each divider one quotient bit per stage, all pipelined
// the whole pipeline holds while a result beat waits on m_axis_tready
// reset (synchronous, active low) clears all valid bits and sets the circle to
// zero and the layer mask to all ones
module circle_box_contact import cbc_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [7:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    // box_min_x, box_min_y, box_max_x, box_max_y, entry_id, entry_layer,
    // entry_user_word
    input  logic [IN_W-1:0]    s_axis_tdata,
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    // hit_id, hit_layer, hit_user_word, normal_x, normal_y, penetration_depth,
    // contact_x, contact_y, center_distance, distance_fraction, zero pad
    output logic [OUT_W-1:0]   m_axis_tdata
);

    logic signed [CW-1:0] r_cx, r_cy;
    logic [CW-2:0]        r_rad;
    logic [31:0]          r_mask;

    t_pipe r_p [NSTAGE];
    t_pipe n_p [NSTAGE];
    logic  en;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx   <= '0;
            r_cy   <= '0;
            r_rad  <= '0;
            r_mask <= '1;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_CENTER_X: r_cx   <= i_cfg_data[CW-1:0];
                CFG_CENTER_Y: r_cy   <= i_cfg_data[CW-1:0];
                CFG_RADIUS:   r_rad  <= i_cfg_data[CW-2:0];
                CFG_MASK:     r_mask <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign en            = !r_p[NSTAGE-1].valid || m_axis_tready;
    assign s_axis_tready = en;

    always_comb begin
        logic [CW:0]       dx, dy;
        logic [2*CW:0]     dsq;
        logic [2*CW-2:0]   t;
        logic [CW-1:0]     num, den, r2;
        logic [CW:0]       r3;
        int                b;
        for (int s = 0; s < NSTAGE; s++) begin
            dx  = '0;
            dy  = '0;
            dsq = '0;
            t   = '0;
            num = '0;
            den = '0;
            r2  = '0;
            r3  = '0;
            b   = 0;
            if (s == 0) begin
                n_p[s]       = '0;
                n_p[s].valid = s_axis_tvalid && (|(s_axis_tdata[4*CW+63:4*CW+32] & r_mask));
                n_p[s].bx0   = s_axis_tdata[CW-1:0];
                n_p[s].by0   = s_axis_tdata[2*CW-1:CW];
                n_p[s].bx1   = s_axis_tdata[3*CW-1:2*CW];
                n_p[s].by1   = s_axis_tdata[4*CW-1:3*CW];
                n_p[s].id    = s_axis_tdata[4*CW+31:4*CW];
                n_p[s].layer = s_axis_tdata[4*CW+63:4*CW+32];
                n_p[s].user  = s_axis_tdata[4*CW+127:4*CW+64];
                n_p[s].cx    = r_cx;
                n_p[s].cy    = r_cy;
                n_p[s].rad   = r_rad;
            end else begin
                n_p[s] = r_p[s-1];
                if (s == ST_CLAMP) begin
                    // lower bound first, so an inverted box still clamps like the model
                    if ($signed(r_p[s-1].cx) < $signed(r_p[s-1].bx0))
                        n_p[s].px = r_p[s-1].bx0;
                    else if ($signed(r_p[s-1].cx) > $signed(r_p[s-1].bx1))
                        n_p[s].px = r_p[s-1].bx1;
                    else
                        n_p[s].px = r_p[s-1].cx;
                    if ($signed(r_p[s-1].cy) < $signed(r_p[s-1].by0))
                        n_p[s].py = r_p[s-1].by0;
                    else if ($signed(r_p[s-1].cy) > $signed(r_p[s-1].by1))
                        n_p[s].py = r_p[s-1].by1;
                    else
                        n_p[s].py = r_p[s-1].cy;
                end else if (s == ST_DIFF) begin
                    dx = {r_p[s-1].cx[CW-1], r_p[s-1].cx} - {r_p[s-1].px[CW-1], r_p[s-1].px};
                    dy = {r_p[s-1].cy[CW-1], r_p[s-1].cy} - {r_p[s-1].py[CW-1], r_p[s-1].py};
                    n_p[s].sx = dx[CW];
                    n_p[s].sy = dy[CW];
                    n_p[s].ax = dx[CW] ? CW'(-dx) : dx[CW-1:0];
                    n_p[s].ay = dy[CW] ? CW'(-dy) : dy[CW-1:0];
                end else if (s == ST_SQR) begin
                    n_p[s].sqx = r_p[s-1].ax * r_p[s-1].ax;
                    n_p[s].sqy = r_p[s-1].ay * r_p[s-1].ay;
                    n_p[s].rsq = r_p[s-1].rad * r_p[s-1].rad;
                end else if (s == ST_HIT) begin
                    dsq = {1'b0, r_p[s-1].sqx} + {1'b0, r_p[s-1].sqy};
                    n_p[s].valid = r_p[s-1].valid && (dsq <= {3'b0, r_p[s-1].rsq});
                    n_p[s].rem   = dsq[2*CW-2:0];
                    n_p[s].root  = '0;
                end else if (s >= ST_SQ0 && s < ST_DINIT) begin
                    // rem holds n - root^2; try setting root bit b
                    b = CW - 2 - (s - ST_SQ0);
                    t = ((2*CW-1)'(r_p[s-1].root) << (b + 1)) + ((2*CW-1)'(1) << (2 * b));
                    if (r_p[s-1].rem >= t) begin
                        n_p[s].rem     = r_p[s-1].rem - t;
                        n_p[s].root[b] = 1'b1;
                    end
                end else if (s == ST_DINIT) begin
                    n_p[s].ctr_in = ({1'b0, r_p[s-1].root} < CW'(EPS_LIMIT));
                    for (int k = 0; k < 3; k++) begin
                        num = (k == 0) ? r_p[s-1].ax :
                              (k == 1) ? r_p[s-1].ay : {1'b0, r_p[s-1].root};
                        den = (k == 2) ? {1'b0, r_p[s-1].rad} : {1'b0, r_p[s-1].root};
                        if (num >= den) begin
                            n_p[s].dr[k] = num - den;
                            n_p[s].dq[k] = (FB+2)'(1);
                        end else begin
                            n_p[s].dr[k] = num;
                            n_p[s].dq[k] = '0;
                        end
                    end
                end else if (s >= ST_DSTEP0 && s < ST_OUT) begin
                    for (int k = 0; k < 3; k++) begin
                        den = (k == 2) ? {1'b0, r_p[s-1].rad} : {1'b0, r_p[s-1].root};
                        r2  = {r_p[s-1].dr[k][CW-2:0], 1'b0};
                        n_p[s].dq[k] = {r_p[s-1].dq[k][FB:0], 1'b0};
                        if (r2 >= den) begin
                            r2 = r2 - den;
                            n_p[s].dq[k][0] = 1'b1;
                        end
                        n_p[s].dr[k] = r2;
                    end
                end else begin
                    // output stage: rounding and the centre-inside case
                    for (int k = 0; k < 3; k++) begin
                        den = (k == 2) ? {1'b0, r_p[s-1].rad} : {1'b0, r_p[s-1].root};
                        r3  = {r_p[s-1].dr[k], 1'b0};
                        if (r3 >= {1'b0, den})
                            n_p[s].dq[k] = r_p[s-1].dq[k] + (FB+2)'(1);
                    end
                    if (r_p[s-1].ctr_in) begin
                        n_p[s].nx   = '0;
                        n_p[s].ny   = (FB+2)'(2 ** FB);
                        n_p[s].pen  = r_p[s-1].rad;
                        n_p[s].ox   = r_p[s-1].cx;
                        n_p[s].oy   = r_p[s-1].cy;
                        n_p[s].dlen = '0;
                        n_p[s].frac = '0;
                    end else begin
                        n_p[s].nx   = r_p[s-1].sx ? -n_p[s].dq[0] : n_p[s].dq[0];
                        n_p[s].ny   = r_p[s-1].sy ? -n_p[s].dq[1] : n_p[s].dq[1];
                        n_p[s].pen  = r_p[s-1].rad - r_p[s-1].root;
                        n_p[s].ox   = r_p[s-1].px;
                        n_p[s].oy   = r_p[s-1].py;
                        n_p[s].dlen = r_p[s-1].root;
                        n_p[s].frac = n_p[s].dq[2][FB:0];
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < NSTAGE; s++)
                r_p[s].valid <= 1'b0;
        end else if (en) begin
            for (int s = 0; s < NSTAGE; s++)
                r_p[s] <= n_p[s];
        end
    end

    assign m_axis_tvalid = r_p[NSTAGE-1].valid;
    assign m_axis_tdata  = {(OUT_W-OUT_BITS)'(0),
                            r_p[NSTAGE-1].frac, r_p[NSTAGE-1].dlen,
                            r_p[NSTAGE-1].oy, r_p[NSTAGE-1].ox,
                            r_p[NSTAGE-1].pen, r_p[NSTAGE-1].ny, r_p[NSTAGE-1].nx,
                            r_p[NSTAGE-1].user, r_p[NSTAGE-1].layer, r_p[NSTAGE-1].id};

    a_frac_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> r_p[NSTAGE-1].frac <= (FB+1)'(2 ** FB))
        else $error("distance fraction above one");

    a_dist_le_rad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> r_p[NSTAGE-1].dlen <= r_p[NSTAGE-1].rad)
        else $error("hit distance beyond radius");

    a_pen_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (r_p[NSTAGE-1].pen + r_p[NSTAGE-1].dlen) == r_p[NSTAGE-1].rad)
        else $error("penetration and distance do not add to radius");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> $stable(r_p[ST_HIT].valid) && $stable(r_p[ST_DINIT].valid))
        else $error("pipeline moved during stall");

endmodule

FILE: dv/cbc_checker.sv
// contact checker for circle_box_contact: watches the config, box and
// contact channels, predicts each contact and compares it; uses cbc_pkg
`timescale 1ns / 100ps
module cbc_checker import cbc_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_valid,
    input  logic             i_cfg_ready,
    input  logic [7:0]       i_cfg_index,
    input  logic [31:0]      i_cfg_data,
    input  logic             i_box_valid,
    input  logic             i_box_ready,
    input  logic [IN_W-1:0]  i_box_data,
    input  logic             i_hit_valid,
    input  logic             i_hit_ready,
    input  logic [OUT_W-1:0] i_hit_data,
    output int               o_fail,
    output int               o_pending
);

    typedef struct {
        logic [31:0] id;
        logic [31:0] layer;
        logic [63:0] user;
        logic [17:0] nx;
        logic [17:0] ny;
        logic [30:0] pen;
        logic [31:0] px;
        logic [31:0] py;
        logic [30:0] dlen;
        logic [16:0] frac;
    } contact_t;

    contact_t    contact_q[$];
    logic [31:0] circ_x, circ_y, layer_mask;
    logic [30:0] circ_r;

    task automatic report(string field, logic [63:0] want, logic [63:0] got);
        $display("mismatch on %s: expected %h, got %h", field, want, got);
        o_fail++;
    endtask

    // round-half-up(num * 2^FB / den)
    function automatic logic [63:0] ratio_q(logic [63:0] num, logic [63:0] den);
        logic [63:0] q, rem;
        q = 0;
        rem = num;
        if (rem >= den) begin
            q = 1;
            rem -= den;
        end
        for (int i = 0; i < FB; i++) begin
            rem = rem << 1;
            q = q << 1;
            if (rem >= den) begin
                rem -= den;
                q |= 1;
            end
        end
        if ((rem << 1) >= den) q++;
        return q;
    endfunction

    function automatic logic [63:0] isqrt(logic [127:0] n);
        logic [63:0] root, cand;
        root = 0;
        for (int b = 63; b >= 0; b--) begin
            cand = root | (64'd1 << b);
            if (128'(cand) * 128'(cand) <= n) root = cand;
        end
        return root;
    endfunction

    function automatic bit predict_contact(logic [IN_W-1:0] beat, output contact_t c);
        longint cx, cy, x0, y0, x1, y1, px, py, dx, dy;
        logic [63:0] ax, ay, dlen, nx, ny;
        logic [127:0] dsq, rsq;
        c.id    = beat[159:128];
        c.layer = beat[191:160];
        c.user  = beat[255:192];
        if ((c.layer & layer_mask) == 0) return 0;
        cx = longint'(signed'(circ_x));
        cy = longint'(signed'(circ_y));
        x0 = longint'(signed'(beat[31:0]));
        y0 = longint'(signed'(beat[63:32]));
        x1 = longint'(signed'(beat[95:64]));
        y1 = longint'(signed'(beat[127:96]));
        // inverted boxes resolve to the min when below it, else the max
        px = cx < x0 ? x0 : (cx > x1 ? x1 : cx);
        py = cy < y0 ? y0 : (cy > y1 ? y1 : cy);
        dx = cx - px;
        dy = cy - py;
        ax = dx < 0 ? -dx : dx;
        ay = dy < 0 ? -dy : dy;
        dsq = 128'(ax) * 128'(ax) + 128'(ay) * 128'(ay);
        rsq = 128'(circ_r) * 128'(circ_r);
        if (dsq > rsq) return 0;
        dlen = isqrt(dsq);
        if (dlen < EPS_LIMIT) begin
            c.nx   = 0;
            c.ny   = 18'(1 << FB);
            c.pen  = circ_r;
            c.px   = circ_x;
            c.py   = circ_y;
            c.dlen = 0;
            c.frac = 0;
        end else begin
            nx = ratio_q(ax, dlen);
            ny = ratio_q(ay, dlen);
            c.nx   = dx < 0 ? 18'(-nx) : 18'(nx);
            c.ny   = dy < 0 ? 18'(-ny) : 18'(ny);
            c.pen  = 31'(64'(circ_r) - dlen);
            c.px   = 32'(px);
            c.py   = 32'(py);
            c.dlen = 31'(dlen);
            c.frac = 17'(ratio_q(dlen, 64'(circ_r)));
        end
        return 1;
    endfunction

    always @(posedge i_clk) begin
        contact_t want, got;
        if (!i_rst_n) begin
            circ_x = 0;
            circ_y = 0;
            circ_r = 0;
            layer_mask = '1;
            contact_q.delete();
            o_fail = 0;
            o_pending = 0;
        end else begin
            // compare before this edge's config write takes effect
            if (i_hit_valid && i_hit_ready) begin
                got.id    = i_hit_data[31:0];
                got.layer = i_hit_data[63:32];
                got.user  = i_hit_data[127:64];
                got.nx    = i_hit_data[145:128];
                got.ny    = i_hit_data[163:146];
                got.pen   = i_hit_data[194:164];
                got.px    = i_hit_data[226:195];
                got.py    = i_hit_data[258:227];
                got.dlen  = i_hit_data[289:259];
                got.frac  = i_hit_data[306:290];
                if (contact_q.size() == 0) begin
                    report("unexpected contact beat, id", 0, got.id);
                end else begin
                    want = contact_q.pop_front();
                    if (got.id != want.id) report("hit_id", want.id, got.id);
                    if (got.layer != want.layer) report("hit_layer", want.layer, got.layer);
                    if (got.user != want.user) report("hit_user_word", want.user, got.user);
                    if (got.nx != want.nx) report("normal_x", want.nx, got.nx);
                    if (got.ny != want.ny) report("normal_y", want.ny, got.ny);
                    if (got.pen != want.pen) report("penetration_depth", want.pen, got.pen);
                    if (got.px != want.px) report("contact_x", want.px, got.px);
                    if (got.py != want.py) report("contact_y", want.py, got.py);
                    if (got.dlen != want.dlen) report("center_distance", want.dlen, got.dlen);
                    if (got.frac != want.frac)
                        report("distance_fraction", want.frac, got.frac);
                end
            end
            if (i_box_valid && i_box_ready && predict_contact(i_box_data, want))
                contact_q = {contact_q, want};
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_CENTER_X: circ_x = i_cfg_data;
                    CFG_CENTER_Y: circ_y = i_cfg_data;
                    CFG_RADIUS:   circ_r = i_cfg_data[30:0];
                    CFG_MASK:     layer_mask = i_cfg_data;
                    default: ;
                endcase
            end
            o_pending = contact_q.size();
        end
    end

endmodule

FILE: dv/tb_top.sv
// testbench top for circle_box_contact: clock, reset, box stimulus, config
// phases, result stall and verdict; depends on cbc_pkg and cbc_checker
`timescale 1ns / 100ps
module tb_top;
    import cbc_pkg::*;

    localparam int STALL_LIMIT = 5000;
    localparam int SETTLE = NSTAGE + 10;

    logic             i_clk = 0;
    logic             i_rst_n = 0;
    logic             i_cfg_valid = 0;
    logic             o_cfg_ready;
    logic [7:0]       i_cfg_index = CFG_CENTER_X;
    logic [31:0]      i_cfg_data = 0;
    logic             s_axis_tvalid = 0;
    logic             s_axis_tready;
    logic [IN_W-1:0]  s_axis_tdata = '0;
    logic             m_axis_tvalid;
    logic             m_axis_tready = 0;
    logic [OUT_W-1:0] m_axis_tdata;

    int   fail_cnt, pending_cnt, quiet_cycles;
    bit   calm = 0;
    longint circ_x, circ_y, circ_r;
    logic [31:0] layer_mask;

    always #2 i_clk = ~i_clk;

    circle_box_contact DUT (.*);

    cbc_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_valid(i_cfg_valid), .i_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_box_valid(s_axis_tvalid), .i_box_ready(s_axis_tready),
        .i_box_data(s_axis_tdata),
        .i_hit_valid(m_axis_tvalid), .i_hit_ready(m_axis_tready),
        .i_hit_data(m_axis_tdata),
        .o_fail(fail_cnt), .o_pending(pending_cnt)
    );

    always @(negedge i_clk)
        m_axis_tready = (calm || !i_rst_n) ? 1'b1 : ($urandom_range(99) >= 35);

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_cfg_valid && o_cfg_ready) || (s_axis_tvalid && s_axis_tready)
                || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic logic [31:0] sat32(longint v);
        if (v > 64'sd2147483647) return 32'h7fffffff;
        if (v < -64'sd2147483648) return 32'h80000000;
        return 32'(v);
    endfunction

    task automatic write_reg(logic [7:0] idx, logic [31:0] val);
        bit rdy;
        @(negedge i_clk);
        i_cfg_valid = 1;
        i_cfg_index = idx;
        i_cfg_data = val;
        forever begin
            #1 rdy = o_cfg_ready;
            @(posedge i_clk);
            if (rdy) break;
            @(negedge i_clk);
        end
        @(negedge i_clk);
        i_cfg_valid = 0;
        case (idx)
            CFG_CENTER_X: circ_x = longint'(signed'(val));
            CFG_CENTER_Y: circ_y = longint'(signed'(val));
            CFG_RADIUS:   circ_r = val[30:0];
            default:      layer_mask = val;
        endcase
    endtask

    task automatic set_circle(logic [31:0] x, logic [31:0] y, logic [31:0] r,
                              logic [31:0] m);
        write_reg(CFG_CENTER_X, x);
        write_reg(CFG_CENTER_Y, y);
        write_reg(CFG_RADIUS, r);
        write_reg(CFG_MASK, m);
    endtask

    task automatic send_box(logic [31:0] x0, logic [31:0] y0, logic [31:0] x1,
                            logic [31:0] y1, logic [31:0] layer);
        bit rdy;
        @(negedge i_clk);
        s_axis_tvalid = 1;
        s_axis_tdata = {{$urandom, $urandom}, layer, $urandom, y1, x1, y0, x0};
        forever begin
            #1 rdy = s_axis_tready;
            @(posedge i_clk);
            if (rdy) break;
            @(negedge i_clk);
        end
        if (!calm && $urandom_range(99) < 35) begin
            @(negedge i_clk);
            s_axis_tvalid = 0;
            repeat ($urandom_range(3)) @(posedge i_clk);
        end
    endtask

    // box placed around the circle so that a good share of beats hit
    task automatic send_near_box();
        longint s, ox, oy, lx, ly;
        logic [31:0] x0, y0, x1, y1, layer;
        s = circ_r > 0 ? (circ_r > (1 << 29) ? (1 << 29) : circ_r) : (1 << 16);
        ox = longint'($urandom_range(0, 32'(4 * s))) - 2 * s;
        oy = longint'($urandom_range(0, 32'(4 * s))) - 2 * s;
        lx = $urandom_range(0, 32'(2 * s));
        ly = $urandom_range(0, 32'(2 * s));
        x0 = sat32(circ_x + ox);
        y0 = sat32(circ_y + oy);
        x1 = sat32(circ_x + ox + lx);
        y1 = sat32(circ_y + oy + ly);
        if ($urandom_range(15) == 0) {x0, x1} = {x1, x0};
        if ($urandom_range(15) == 0) {y0, y1} = {y1, y0};
        layer = $urandom;
        if ($urandom_range(7) == 0) layer = layer & ~layer_mask;
        if ($urandom_range(9) == 0)
            send_box($urandom, $urandom, $urandom, $urandom, layer);
        else
            send_box(x0, y0, x1, y1, layer);
    endtask

    task automatic settle();
        @(negedge i_clk);
        s_axis_tvalid = 0;
        while (pending_cnt != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    initial begin
        circ_x = 0;
        circ_y = 0;
        circ_r = 0;
        layer_mask = '1;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        // reset circle: zero radius at the origin, only a covering box hits
        send_box(32'hffff0000, 32'hffff0000, 32'h00010000, 32'h00010000, 32'h1);
        send_box(32'h00010000, 32'h00010000, 32'h00020000, 32'h00020000, 32'hffffffff);
        settle();

        set_circle(32'h00050000, 32'h00050000, 32'h00030000, 32'hffffffff);
        send_box(32'h00040000, 32'h00040000, 32'h00060000, 32'h00060000, 32'h1);
        send_box(32'h00070000, 32'h00000000, 32'h00090000, 32'h00090000, 32'h2);
        send_box(32'h00000000, 32'h00070000, 32'h00090000, 32'h00090000, 32'h4);
        send_box(32'h00070000, 32'h00070000, 32'h00090000, 32'h00090000, 32'h8);
        send_box(32'hfffb0000, 32'hfffb0000, 32'h00030000, 32'h00030000, 32'h10);
        send_box(32'h00080000, 32'h00050000, 32'h00090000, 32'h00060000, 32'h20);
        send_box(32'h00080001, 32'h00050000, 32'h00090000, 32'h00060000, 32'h40);
        send_box(32'h00040000, 32'h00040000, 32'h00060000, 32'h00060000, 32'h0);
        send_box(32'h00070000, 32'h00060000, 32'h00060000, 32'h00040000, 32'h80);
        send_box(32'h00020000, 32'h00070000, 32'h00010000, 32'h00060000, 32'h80000000);
        send_box(32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'hffffffff);
        send_box(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'hffffffff);
        send_box(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 32'hffffffff);
        settle();

        set_circle(32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h00ff00ff);
        send_box(32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000, 32'h1);
        send_box(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 32'h1);
        send_box(32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h1);
        send_box(32'h00000000, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h00010000);
        for (int i = 0; i < 160; i++) send_near_box();
        settle();

        calm = 1;
        set_circle($urandom_range(32'h00ffffff), $urandom, 32'h000a0000, 32'hffffffff);
        for (int i = 0; i < 200; i++) send_near_box();
        settle();
        calm = 0;

        set_circle($urandom, $urandom, 32'h0, $urandom | 32'h1);
        for (int i = 0; i < 130; i++) send_near_box();
        settle();

        set_circle($urandom, $urandom, $urandom >> 1, $urandom | 32'h100);
        for (int i = 0; i < 200; i++) send_near_box();
        settle();

        set_circle($urandom, $urandom, $urandom_range(1, 4), 32'hffffffff);
        for (int i = 0; i < 100; i++) send_near_box();
        settle();

        set_circle($urandom, $urandom, 32'h7fffffff, 32'h0);
        for (int i = 0; i < 30; i++) send_near_box();
        settle();

        set_circle($urandom_range(32'h0fffffff), $urandom_range(32'h0fffffff),
                   $urandom_range(32'h00010000, 32'h01000000), 32'hf0f0f0f0);
        for (int i = 0; i < 200; i++) send_near_box();
        settle();

        if (fail_cnt == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
